// ----- hdl/cc2p_pkg.sv -----
// cc2p_pkg: shared types and constants of the cartesian-to-polar cordic pipeline
// q2.14 coordinate path, q3.13 angle path, arctangent table and magnitude gain
// no dependencies
package cc2p_pkg;

  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 31;
  localparam int PROD_W  = COORD_W + GAIN_W - 1;
  localparam int FRAC_SH = 30;
  localparam int MAX_SHIFTS = 16;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [GAIN_W-1:0]  GAIN_Q30    = 31'sd652051196;
  localparam logic signed [PROD_W-1:0]  ROUND_Q30   = 46'sd536870912;

  // largest angle the datapath can reach: pi/2 plus the sum of the table
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd27148;

  // atan(2^-i) rounded to q3.13
  localparam logic signed [ANGLE_W-1:0] ATAN_Q13 [MAX_SHIFTS] = '{
    16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256, 16'sd128, 16'sd64,
    16'sd32,   16'sd16,   16'sd8,    16'sd4,    16'sd2,   16'sd1,   16'sd0,   16'sd0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [ANGLE_W-1:0] a;
  } cc2p_vec_t;

endpackage

// ----- hdl/cc2p_ifs.sv -----
// cc2p_ifs: valid/ready channel interfaces for point words and polar words
// depends on cc2p_pkg for field widths
interface cc2p_in_if import cc2p_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface cc2p_out_if import cc2p_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] magnitude;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

// ----- hdl/cc2p_iter.sv -----
// cc2p_iter: one registered cordic vectoring micro-rotation
// depends on cc2p_pkg (vector type, arctangent table)
module cc2p_iter import cc2p_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      valid_in,
  input  cc2p_vec_t vec_in,
  output logic      valid_out,
  output cc2p_vec_t vec_out
);

  logic                      valid_r;
  cc2p_vec_t                 vec_r;
  cc2p_vec_t                 vec_nxt;
  logic signed [COORD_W-1:0] dx;
  logic signed [COORD_W-1:0] dy;

  assign dx = vec_in.x >>> SHIFT;
  assign dy = vec_in.y >>> SHIFT;

  // rotate toward y = 0, zero y takes the counter-clockwise branch
  always_comb begin
    if (vec_in.y > 16'sd0) begin
      vec_nxt.x = vec_in.x + dy;
      vec_nxt.y = vec_in.y - dx;
      vec_nxt.a = vec_in.a + ATAN_Q13[SHIFT];
    end else begin
      vec_nxt.x = vec_in.x - dy;
      vec_nxt.y = vec_in.y + dx;
      vec_nxt.a = vec_in.a - ATAN_Q13[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign valid_out = valid_r;
  assign vec_out   = vec_r;

endmodule

// ----- hdl/cordic_cartesian_to_polar.sv -----
// cordic_cartesian_to_polar: pipelined cordic vectoring, (x, y) q2.14 -> magnitude, angle
// stages in order: pre-rotation, one stage per micro-rotation, gain multiply, output
// throughput one word per cycle; the whole pipeline holds while a result word waits at the output
// reset (synchronous, rst_n low) clears every stage valid bit, payload registers are not reset
// depends on cc2p_pkg, cc2p_ifs (channel interfaces) and cc2p_iter
module cordic_cartesian_to_polar import cc2p_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cc2p_in_if.sink     in_ch,
  cc2p_out_if.source  out_ch
);

  // pipeline advance: the output register is empty or being drained
  logic adv;
  assign adv        = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------------------------------------------------------------
  // stage 0: quarter-turn pre-rotation into the right half plane
  // ---------------------------------------------------------------------
  cc2p_vec_t pre_nxt;
  cc2p_vec_t pre_r;
  logic      pre_valid_r;

  always_comb begin
    if (in_ch.y_coord > 16'sd0) begin
      // clockwise quarter-turn start: angle begins at +pi/2
      pre_nxt.x = in_ch.y_coord;
      pre_nxt.y = -in_ch.x_coord;
      pre_nxt.a = HALF_PI_Q13;
    end else begin
      // zero or negative y: angle begins at -pi/2
      pre_nxt.x = -in_ch.y_coord;
      pre_nxt.y = in_ch.x_coord;
      pre_nxt.a = -HALF_PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (adv) begin
      pre_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r <= pre_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stages 1..ITERATIONS: one shift-add micro-rotation each
  // ---------------------------------------------------------------------
  cc2p_vec_t vec   [ITERATIONS+1];
  logic      vld   [ITERATIONS+1];

  assign vec[0] = pre_r;
  assign vld[0] = pre_valid_r;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    cc2p_iter #(
      .SHIFT (i)
    ) u_iter (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .valid_in  (vld[i]),
      .vec_in    (vec[i]),
      .valid_out (vld[i+1]),
      .vec_out   (vec[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // gain stage: x times 0.60727 in q30, full 46-bit product registered
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ANGLE_W-1:0] mul_ang_r;
  logic                      mul_valid_r;

  assign prod_nxt = vec[ITERATIONS].x * GAIN_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (adv) begin
      mul_valid_r <= vld[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= prod_nxt;
      mul_ang_r <= vec[ITERATIONS].a;
    end
  end

  // ---------------------------------------------------------------------
  // output stage: round half up to q2.14 (floor of product + 2^29 over 2^30)
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0]  rnd;
  logic signed [COORD_W-1:0] mag_nxt;
  logic signed [COORD_W-1:0] mag_r;
  logic signed [ANGLE_W-1:0] ang_r;
  logic                      out_valid_r;

  assign rnd     = prod_r + ROUND_Q30;
  assign mag_nxt = rnd[FRAC_SH +: COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag_nxt;
      ang_r <= mul_ang_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.magnitude = mag_r;
  assign out_ch.angle     = ang_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------

  // the pre-rotation always seeds the angle with plus or minus pi/2
  a_pre_angle: assert property (@(posedge clk) disable iff (!rst_n)
    pre_valid_r |-> (pre_r.a == HALF_PI_Q13 || pre_r.a == -HALF_PI_Q13))
    else $error("pre-rotation angle seed is not +/- pi/2");

  // the angle accumulator never leaves pi/2 plus the arctangent sum
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.angle <= ANGLE_LIMIT && out_ch.angle >= -ANGLE_LIMIT))
    else $error("output angle outside the reachable range");

  // a word in the gain stage reaches the output register on an advance
  a_gain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mul_valid_r) |=> out_ch.valid)
    else $error("word lost between gain stage and output register");

endmodule
